// ----- rtl/rs_steganalysis_group_counter_assert.svh -----
// Assertion macros used by the checker file of this block.
`ifndef RS_STEGANALYSIS_GROUP_COUNTER_ASSERT_SVH
`define RS_STEGANALYSIS_GROUP_COUNTER_ASSERT_SVH

// A property that is checked only while the block is out of reset.
`define RSGC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A property that is checked at every edge, reset included.
`define RSGC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/rsgc_pkg.sv -----
`default_nettype none

package rsgc_pkg;

    // Counter slots, in the order in which they leave the block.
    localparam int unsigned NUM_COUNTERS    = 9;
    localparam int unsigned CNT_W           = 32;
    localparam int unsigned CNT_REGULAR     = 0;
    localparam int unsigned CNT_SINGULAR    = 1;
    localparam int unsigned CNT_NEG_REG     = 2;
    localparam int unsigned CNT_NEG_SING    = 3;
    localparam int unsigned CNT_FLIP_REG    = 4;
    localparam int unsigned CNT_FLIP_SING   = 5;
    localparam int unsigned CNT_FLIP_NEGREG = 6;
    localparam int unsigned CNT_FLIP_NEGSNG = 7;
    localparam int unsigned CNT_TOTAL       = 8;

    localparam int unsigned PIX_W    = 8;
    // A shifted flip reaches -1 and 256, so changed pixels need ten signed bits.
    localparam int unsigned SPIX_W   = PIX_W + 2;
    // Four absolute differences of at most 257 each.
    localparam int unsigned SMOOTH_W = PIX_W + 3;

    // Masks per group; each counter moves by at most this much per transaction.
    localparam logic [1:0] MASKS_PER_GROUP = 2'd2;

    typedef logic [CNT_W-1:0]           t_count;
    typedef logic signed [SPIX_W-1:0]   t_spix;
    typedef logic [SMOOTH_W-1:0]        t_smooth;

    // Per-item increments of the four counters that belong to one group copy.
    typedef struct packed {
        logic [1:0] reg_pos;
        logic [1:0] sing_pos;
        logic [1:0] reg_neg;
        logic [1:0] sing_neg;
    } t_incr;

    // Pixel widened to signed form, unchanged.
    function automatic t_spix widen(input logic [PIX_W-1:0] v);
        return t_spix'({2'b00, v});
    endfunction

    // LSB flip, stays in 0..255.
    function automatic t_spix flip_pos(input logic [PIX_W-1:0] v);
        return t_spix'({2'b00, v ^ 8'h01});
    endfunction

    // Shifted flip: odd values step up, even values step down.
    function automatic t_spix flip_neg(input logic [PIX_W-1:0] v);
        t_spix w;
        w = widen(v);
        return v[0] ? (w + t_spix'(1)) : (w - t_spix'(1));
    endfunction

    function automatic logic [PIX_W:0] abs_diff(input t_spix x, input t_spix y);
        t_spix d;
        d = x - y;
        return d[SPIX_W-1] ? (PIX_W+1)'(-d) : (PIX_W+1)'(d);
    endfunction

    // Sum of absolute differences around the cycle a-b, b-d, d-c, c-a.
    function automatic t_smooth smooth(input t_spix a, input t_spix b,
                                       input t_spix c, input t_spix d);
        return t_smooth'(abs_diff(a, b)) + t_smooth'(abs_diff(b, d))
             + t_smooth'(abs_diff(d, c)) + t_smooth'(abs_diff(c, a));
    endfunction

    // Both masks on one group copy: mask 0 changes a and d, mask 1 changes b and c.
    function automatic t_incr count_group(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b,
                                          input logic [PIX_W-1:0] c, input logic [PIX_W-1:0] d);
        t_smooth sb;
        t_smooth sp0;
        t_smooth sn0;
        t_smooth sp1;
        t_smooth sn1;
        t_incr   r;
        sb  = smooth(widen(a), widen(b), widen(c), widen(d));
        sp0 = smooth(flip_pos(a), widen(b), widen(c), flip_pos(d));
        sn0 = smooth(flip_neg(a), widen(b), widen(c), flip_neg(d));
        sp1 = smooth(widen(a), flip_pos(b), flip_pos(c), widen(d));
        sn1 = smooth(widen(a), flip_neg(b), flip_neg(c), widen(d));
        r.reg_pos  = {1'b0, sp0 > sb} + {1'b0, sp1 > sb};
        r.sing_pos = {1'b0, sp0 < sb} + {1'b0, sp1 < sb};
        r.reg_neg  = {1'b0, sn0 > sb} + {1'b0, sn1 > sb};
        r.sing_neg = {1'b0, sn0 < sb} + {1'b0, sn1 < sb};
        return r;
    endfunction

    // Counter plus a small step, held at all ones once it gets there.
    function automatic t_count sat_add(input t_count base, input logic [1:0] step);
        logic [CNT_W:0] sum;
        sum = {1'b0, base} + (CNT_W+1)'(step);
        return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/rsgc_group_if.sv -----
`default_nettype none

// Channel carrying one 2x2 pixel group per transaction.
interface rsgc_group_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_a;
    logic [7:0] pixel_b;
    logic [7:0] pixel_c;
    logic [7:0] pixel_d;
    logic       clear_counts;

    modport source (
        output valid, pixel_a, pixel_b, pixel_c, pixel_d, clear_counts,
        input  ready
    );
    modport sink (
        input  valid, pixel_a, pixel_b, pixel_c, pixel_d, clear_counts,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/rsgc_count_if.sv -----
`default_nettype none

// Channel carrying the nine counter values per transaction.
interface rsgc_count_if;
    logic        valid;
    logic        ready;
    logic [31:0] regular_count;
    logic [31:0] singular_count;
    logic [31:0] neg_regular_count;
    logic [31:0] neg_singular_count;
    logic [31:0] flip_regular_count;
    logic [31:0] flip_singular_count;
    logic [31:0] flip_neg_regular_count;
    logic [31:0] flip_neg_singular_count;
    logic [31:0] total_groups;

    modport source (
        output valid, regular_count, singular_count, neg_regular_count,
               neg_singular_count, flip_regular_count, flip_singular_count,
               flip_neg_regular_count, flip_neg_singular_count, total_groups,
        input  ready
    );
    modport sink (
        input  valid, regular_count, singular_count, neg_regular_count,
               neg_singular_count, flip_regular_count, flip_singular_count,
               flip_neg_regular_count, flip_neg_singular_count, total_groups,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/rs_steganalysis_group_counter.sv -----
// RS steganalysis group counter. Each transaction on i_group brings one 2x2 pixel group and
// yields exactly one transaction on o_counts carrying all nine saturating 32-bit counters as
// they stand after that group. The block takes one group per clock cycle while o_counts is not
// stalled; a group is held in the input register and its counters are then registered in the
// counter register, which drives o_counts. While a result waits on o_counts the input register
// still takes a group, so an output stall stops the input only once that register is full.
// Setting clear_counts zeroes every counter before that group is counted. total_groups grows
// by two per group; all counters hold at 4294967295 once they reach it.
`default_nettype none

module rs_steganalysis_group_counter (
    input  wire           i_clk,
    input  wire           i_rst_n,
    rsgc_group_if.sink    i_group,
    rsgc_count_if.source  o_counts
);

    // Input register.
    logic                         r_s1_valid;
    logic [rsgc_pkg::PIX_W-1:0]   r_a;
    logic [rsgc_pkg::PIX_W-1:0]   r_b;
    logic [rsgc_pkg::PIX_W-1:0]   r_c;
    logic [rsgc_pkg::PIX_W-1:0]   r_d;
    logic                         r_clear;

    // Counter register, which is also the result register.
    logic                         r_out_valid;
    rsgc_pkg::t_count             r_cnt [rsgc_pkg::NUM_COUNTERS];
    rsgc_pkg::t_count             n_cnt [rsgc_pkg::NUM_COUNTERS];

    logic                         advance;
    logic                         in_take;
    rsgc_pkg::t_incr              inc_orig;
    rsgc_pkg::t_incr              inc_flip;
    logic [1:0]                   step [rsgc_pkg::NUM_COUNTERS];

    // Pipeline control: the held group moves on when the result slot is free or emptying.
    assign advance       = r_s1_valid && (!r_out_valid || o_counts.ready);
    assign i_group.ready = !r_s1_valid || advance;
    assign in_take       = i_group.valid && i_group.ready;

    // Group evaluation on the original pixels and on the LSB-flipped copy.
    always_comb begin
        inc_orig = rsgc_pkg::count_group(r_a, r_b, r_c, r_d);
        inc_flip = rsgc_pkg::count_group(r_a ^ 8'h01, r_b ^ 8'h01, r_c ^ 8'h01, r_d ^ 8'h01);
        step[rsgc_pkg::CNT_REGULAR]     = inc_orig.reg_pos;
        step[rsgc_pkg::CNT_SINGULAR]    = inc_orig.sing_pos;
        step[rsgc_pkg::CNT_NEG_REG]     = inc_orig.reg_neg;
        step[rsgc_pkg::CNT_NEG_SING]    = inc_orig.sing_neg;
        step[rsgc_pkg::CNT_FLIP_REG]    = inc_flip.reg_pos;
        step[rsgc_pkg::CNT_FLIP_SING]   = inc_flip.sing_pos;
        step[rsgc_pkg::CNT_FLIP_NEGREG] = inc_flip.reg_neg;
        step[rsgc_pkg::CNT_FLIP_NEGSNG] = inc_flip.sing_neg;
        step[rsgc_pkg::CNT_TOTAL]       = rsgc_pkg::MASKS_PER_GROUP;
    end

    // Next counter values, starting from zero when the group asks for a clear.
    always_comb begin
        for (int j = 0; j < rsgc_pkg::NUM_COUNTERS; j++) begin
            n_cnt[j] = rsgc_pkg::sat_add(r_clear ? '0 : r_cnt[j], step[j]);
        end
    end

    // Control registers and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int j = 0; j < rsgc_pkg::NUM_COUNTERS; j++) begin
                r_cnt[j] <= '0;
            end
        end else begin
            if (i_group.ready) begin
                r_s1_valid <= i_group.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_cnt       <= n_cnt;
            end else if (o_counts.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Input payload capture.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_a     <= i_group.pixel_a;
            r_b     <= i_group.pixel_b;
            r_c     <= i_group.pixel_c;
            r_d     <= i_group.pixel_d;
            r_clear <= i_group.clear_counts;
        end
    end

    // Result channel.
    assign o_counts.valid                   = r_out_valid;
    assign o_counts.regular_count           = r_cnt[rsgc_pkg::CNT_REGULAR];
    assign o_counts.singular_count          = r_cnt[rsgc_pkg::CNT_SINGULAR];
    assign o_counts.neg_regular_count       = r_cnt[rsgc_pkg::CNT_NEG_REG];
    assign o_counts.neg_singular_count      = r_cnt[rsgc_pkg::CNT_NEG_SING];
    assign o_counts.flip_regular_count      = r_cnt[rsgc_pkg::CNT_FLIP_REG];
    assign o_counts.flip_singular_count     = r_cnt[rsgc_pkg::CNT_FLIP_SING];
    assign o_counts.flip_neg_regular_count  = r_cnt[rsgc_pkg::CNT_FLIP_NEGREG];
    assign o_counts.flip_neg_singular_count = r_cnt[rsgc_pkg::CNT_FLIP_NEGSNG];
    assign o_counts.total_groups            = r_cnt[rsgc_pkg::CNT_TOTAL];

endmodule

`default_nettype wire

// ----- rtl/rsgc_checker.sv -----
`default_nettype none

`include "rs_steganalysis_group_counter_assert.svh"

module rsgc_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_out_valid,
    input wire        i_out_ready,
    input wire [31:0] i_regular,
    input wire [31:0] i_singular,
    input wire [31:0] i_total
);

    // No result is offered in the cycle after reset.
    `RSGC_ASSERT_ALWAYS(a_no_result_after_reset, i_clk, !i_rst_n |=> !i_out_valid, "result offered after reset")

    // A stalled result stays valid and keeps its regular and total counts.
    `RSGC_ASSERT(a_stall_holds, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_regular) && $stable(i_total)), "stalled result changed")

    // Every mask application counts toward the total, so it bounds the F1 counts.
    `RSGC_ASSERT(a_total_bounds, i_clk, i_rst_n, (i_regular <= i_total) && (i_singular <= i_total), "F1 count above total")

    // The total moves in steps of two until it saturates.
    `RSGC_ASSERT(a_total_even, i_clk, i_rst_n, (i_total[0] == 1'b0) || (i_total == 32'hFFFF_FFFF), "odd total below saturation")

endmodule

bind rs_steganalysis_group_counter rsgc_checker u_rsgc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_counts.valid),
    .i_out_ready (o_counts.ready),
    .i_regular   (o_counts.regular_count),
    .i_singular  (o_counts.singular_count),
    .i_total     (o_counts.total_groups)
);

`default_nettype wire

// ----- test/tb_rs_steganalysis_group_counter.sv -----
`timescale 1ns / 1ps

module tb_rs_steganalysis_group_counter;

    localparam int unsigned STALL_LIMIT   = 2000;
    localparam int unsigned HOLD_CYCLES   = 80;
    localparam int unsigned REPORT_LIMIT  = 10;
    localparam int unsigned IDLE_PERCENT  = 8;
    localparam int unsigned DRAIN_CYCLES  = 10;

    // Pixel positions within a group: a b on top, c d below.
    localparam int PIX_A = 0;
    localparam int PIX_B = 1;
    localparam int PIX_C = 2;
    localparam int PIX_D = 3;
    localparam int GROUP_PIXELS = 4;

    typedef logic [rsgc_pkg::NUM_COUNTERS-1:0][rsgc_pkg::CNT_W-1:0] t_counter_set;

    typedef struct {
        logic [7:0] pix [GROUP_PIXELS];
        logic       clear;
    } t_group;

    // Shapes of random pixel groups.
    typedef enum {PATTERN_SMOOTH, PATTERN_WIDE, PATTERN_EXTREME} t_pattern;

    // Keeps its own copy of the nine counters and the counter sets still owed by the block.
    class group_count_tracker;
        t_counter_set counters;
        t_counter_set expected_counts [$];
        int unsigned  mismatches;

        function new();
            counters   = '0;
            mismatches = 0;
        endfunction

        function int unsigned pending();
            return expected_counts.size();
        endfunction

        function void bump(int unsigned idx);
            if (counters[idx] != '1) begin
                counters[idx] = counters[idx] + 1;
            end
        endfunction

        function int abs_gap(int x, int y);
            return (x > y) ? x - y : y - x;
        endfunction

        // Absolute differences around the ring a-b, b-d, d-c, c-a.
        function int ring_smoothness(int p [GROUP_PIXELS]);
            return abs_gap(p[PIX_A], p[PIX_B]) + abs_gap(p[PIX_B], p[PIX_D])
                 + abs_gap(p[PIX_D], p[PIX_C]) + abs_gap(p[PIX_C], p[PIX_A]);
        endfunction

        // Both checkerboard masks on one copy of the group. The first mask takes a and d,
        // the second b and c; base selects the plain or the pre-flipped counter bank.
        function void tally_copy(int g [GROUP_PIXELS], int unsigned base, bit count_total);
            int  plain;
            int  lsb_flipped;
            int  shifted;
            bit  covered;
            int  pp [GROUP_PIXELS];
            int  pn [GROUP_PIXELS];
            plain = ring_smoothness(g);
            for (int m = 0; m < 2; m++) begin
                for (int k = 0; k < GROUP_PIXELS; k++) begin
                    covered = ((((k / 2) + (k % 2)) % 2) == 0) == (m == 0);
                    if (covered) begin
                        pp[k] = g[k] ^ 1;
                        pn[k] = (g[k] % 2 == 1) ? g[k] + 1 : g[k] - 1;
                    end else begin
                        pp[k] = g[k];
                        pn[k] = g[k];
                    end
                end
                lsb_flipped = ring_smoothness(pp);
                shifted     = ring_smoothness(pn);
                if (lsb_flipped > plain) bump(base + rsgc_pkg::CNT_REGULAR);
                if (lsb_flipped < plain) bump(base + rsgc_pkg::CNT_SINGULAR);
                if (shifted > plain)     bump(base + rsgc_pkg::CNT_NEG_REG);
                if (shifted < plain)     bump(base + rsgc_pkg::CNT_NEG_SING);
                if (count_total)         bump(rsgc_pkg::CNT_TOTAL);
            end
        endfunction

        // Called for every group the block accepts.
        function void note_group(t_group grp);
            int g  [GROUP_PIXELS];
            int gf [GROUP_PIXELS];
            if (grp.clear) begin
                counters = '0;
            end
            for (int k = 0; k < GROUP_PIXELS; k++) begin
                g[k]  = int'(grp.pix[k]);
                gf[k] = g[k] ^ 1;
            end
            tally_copy(g, rsgc_pkg::CNT_REGULAR, 1'b1);
            tally_copy(gf, rsgc_pkg::CNT_FLIP_REG, 1'b0);
            expected_counts.push_back(counters);
        endfunction

        function string counter_name(int unsigned idx);
            case (idx)
                rsgc_pkg::CNT_REGULAR:     return "regular_count";
                rsgc_pkg::CNT_SINGULAR:    return "singular_count";
                rsgc_pkg::CNT_NEG_REG:     return "neg_regular_count";
                rsgc_pkg::CNT_NEG_SING:    return "neg_singular_count";
                rsgc_pkg::CNT_FLIP_REG:    return "flip_regular_count";
                rsgc_pkg::CNT_FLIP_SING:   return "flip_singular_count";
                rsgc_pkg::CNT_FLIP_NEGREG: return "flip_neg_regular_count";
                rsgc_pkg::CNT_FLIP_NEGSNG: return "flip_neg_singular_count";
                default:                   return "total_groups";
            endcase
        endfunction

        // Called for every counter transaction taken from the block.
        function void check_counts(t_counter_set got);
            t_counter_set want;
            if (expected_counts.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("unexpected counter transaction at %0t", $realtime);
                end
                return;
            end
            want = expected_counts.pop_front();
            for (int unsigned i = 0; i < rsgc_pkg::NUM_COUNTERS; i++) begin
                if (got[i] !== want[i]) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("%s mismatch at %0t: expected %0d, got %0d",
                                 counter_name(i), $realtime, want[i], got[i]);
                    end
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   quiet_sender;
    bit   quiet_sink;
    bit   hold_request;

    group_count_tracker tracker = new();

    rsgc_group_if group_bus ();
    rsgc_count_if count_bus ();

    rs_steganalysis_group_counter u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_group  (group_bus),
        .o_counts (count_bus)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_group make_group(int a, int b, int c, int d, bit clr);
        t_group grp;
        grp.pix[PIX_A] = 8'(a);
        grp.pix[PIX_B] = 8'(b);
        grp.pix[PIX_C] = 8'(c);
        grp.pix[PIX_D] = 8'(d);
        grp.clear      = clr;
        return grp;
    endfunction

    // Natural-looking groups half the time, with wide and saturating ones mixed in.
    function automatic t_group random_group();
        t_group   grp;
        t_pattern shape;
        int       centre;
        int       v;
        int unsigned pick;
        pick   = $urandom_range(99);
        shape  = (pick < 50) ? PATTERN_SMOOTH : (pick < 80) ? PATTERN_WIDE : PATTERN_EXTREME;
        centre = $urandom_range(255);
        for (int k = 0; k < GROUP_PIXELS; k++) begin
            case (shape)
                PATTERN_SMOOTH: begin
                    v = centre + int'($urandom_range(6)) - 3;
                    if (v < 0) v = 0;
                    if (v > 255) v = 255;
                end
                PATTERN_WIDE: begin
                    v = $urandom_range(255);
                end
                default: begin
                    case ($urandom_range(4))
                        0: v = 0;
                        1: v = 1;
                        2: v = 254;
                        3: v = 255;
                        default: v = $urandom_range(255);
                    endcase
                end
            endcase
            grp.pix[k] = 8'(v);
        end
        grp.clear = ($urandom_range(99) < 2);
        return grp;
    endfunction

    // Offers one group and returns at the edge where it is taken.
    task automatic drive_group(input t_group grp);
        if (!quiet_sender && $urandom_range(99) < IDLE_PERCENT) begin
            group_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        group_bus.valid        <= 1'b1;
        group_bus.pixel_a      <= grp.pix[PIX_A];
        group_bus.pixel_b      <= grp.pix[PIX_B];
        group_bus.pixel_c      <= grp.pix[PIX_C];
        group_bus.pixel_d      <= grp.pix[PIX_D];
        group_bus.clear_counts <= grp.clear;
        @(posedge i_clk);
        while (!group_bus.ready) @(posedge i_clk);
        tracker.note_group(grp);
    endtask

    task automatic drive_random(input int unsigned count);
        repeat (count) drive_group(random_group());
    endtask

    task automatic wait_for_drain();
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    // Result side: takes counter transactions, stalls at random or for a long hold-off.
    initial begin
        int unsigned  hold_left;
        t_counter_set got;
        hold_left = 0;
        count_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && count_bus.valid && count_bus.ready) begin
                got[rsgc_pkg::CNT_REGULAR]     = count_bus.regular_count;
                got[rsgc_pkg::CNT_SINGULAR]    = count_bus.singular_count;
                got[rsgc_pkg::CNT_NEG_REG]     = count_bus.neg_regular_count;
                got[rsgc_pkg::CNT_NEG_SING]    = count_bus.neg_singular_count;
                got[rsgc_pkg::CNT_FLIP_REG]    = count_bus.flip_regular_count;
                got[rsgc_pkg::CNT_FLIP_SING]   = count_bus.flip_singular_count;
                got[rsgc_pkg::CNT_FLIP_NEGREG] = count_bus.flip_neg_regular_count;
                got[rsgc_pkg::CNT_FLIP_NEGSNG] = count_bus.flip_neg_singular_count;
                got[rsgc_pkg::CNT_TOTAL]       = count_bus.total_groups;
                tracker.check_counts(got);
            end
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left != 0) begin
                hold_left--;
                count_bus.ready <= 1'b0;
            end else begin
                count_bus.ready <= quiet_sink || ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    // Watchdog: ends the run once neither channel has moved for too long.
    initial begin
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (group_bus.valid && group_bus.ready)
                    || (count_bus.valid && count_bus.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("tb_rs_steganalysis_group_counter: done, errors");
        $finish;
    end

    // Stimulus sequence.
    initial begin
        i_rst_n                <= 1'b0;
        group_bus.valid        <= 1'b0;
        group_bus.pixel_a      <= '0;
        group_bus.pixel_b      <= '0;
        group_bus.pixel_c      <= '0;
        group_bus.pixel_d      <= '0;
        group_bus.clear_counts <= 1'b0;
        quiet_sender = 1'b0;
        quiet_sink   = 1'b0;
        hold_request = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed groups: flat, extreme, shifted flips that leave 0..255, ties and clears.
        drive_group(make_group(0, 0, 0, 0, 1'b1));
        drive_group(make_group(255, 255, 255, 255, 1'b0));
        drive_group(make_group(0, 255, 255, 0, 1'b0));
        drive_group(make_group(255, 0, 0, 255, 1'b0));
        drive_group(make_group(1, 1, 1, 1, 1'b0));
        drive_group(make_group(254, 254, 254, 254, 1'b0));
        drive_group(make_group(0, 1, 2, 3, 1'b0));
        drive_group(make_group(255, 254, 253, 252, 1'b0));
        drive_group(make_group(128, 128, 129, 129, 1'b0));
        drive_group(make_group(0, 0, 255, 255, 1'b0));
        drive_group(make_group(1, 254, 254, 1, 1'b0));
        drive_group(make_group(100, 100, 100, 101, 1'b0));
        drive_group(make_group(0, 0, 0, 0, 1'b1));
        drive_group(make_group(7, 200, 13, 90, 1'b0));
        drive_group(make_group(255, 0, 255, 0, 1'b0));
        drive_group(make_group(1, 0, 1, 0, 1'b0));
        drive_group(make_group(170, 85, 85, 170, 1'b0));
        drive_group(make_group(127, 128, 128, 127, 1'b0));
        drive_group(make_group(2, 2, 3, 3, 1'b1));
        drive_group(make_group(50, 52, 48, 51, 1'b0));

        // Random groups with idling on both sides.
        drive_random(550);

        // A long stretch without any idling.
        quiet_sender = 1'b1;
        quiet_sink   = 1'b1;
        drive_random(400);

        // The result side holds off while groups keep coming, so the input backs up.
        quiet_sender = 1'b0;
        quiet_sink   = 1'b0;
        hold_request = 1'b1;
        drive_random(200);

        // Sender pauses until every counter transaction has come back.
        group_bus.valid <= 1'b0;
        wait_for_drain();
        drive_random(500);

        group_bus.valid <= 1'b0;
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("tb_rs_steganalysis_group_counter: done, clean");
        end else begin
            $display("tb_rs_steganalysis_group_counter: done, errors");
        end
        $finish;
    end

endmodule
